FILE: hdl/nsv_pkg.sv
// Package for the NMEA sentence validator: error codes, character constants,
// header match patterns and the hex digit decoder.
// No dependencies.
package nsv_pkg;

  localparam int unsigned HDR_LEN   = 6;
  localparam int unsigned NUM_KINDS = 4;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_DOLLAR   = 3'd1;
  localparam logic [2:0] ERR_CHAR     = 3'd2;
  localparam logic [2:0] ERR_STAR     = 3'd3;
  localparam logic [2:0] ERR_DIGITS   = 3'd4;
  localparam logic [2:0] ERR_HEX      = 3'd5;
  localparam logic [2:0] ERR_MISMATCH = 3'd6;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] PRINT_LO  = 8'd32;
  localparam logic [7:0] PRINT_HI  = 8'd126;

  localparam logic [7:0] MAX_BODY_RST = 8'd120;

  // Header patterns, first character in the top byte.
  localparam logic [8*HDR_LEN-1:0] HDR_PAT [NUM_KINDS] =
    '{"$GNGGA", "$GNGLL", "$GNRMC", "$GNVTG"};

  typedef struct packed {
    logic       bad;
    logic [3:0] val;
  } hex_t;

  // Expected header byte for a kind at a header position.
  function automatic logic [7:0] hdr_byte(input logic [1:0] kind, input logic [2:0] pos);
    logic [7:0] res;
    res = 8'h00;
    for (int p = 0; p < HDR_LEN; p++) begin
      if (pos == 3'(p)) begin
        res = HDR_PAT[kind][8*(HDR_LEN-1-p) +: 8];
      end
    end
    return res;
  endfunction

  // Hex digit of either case.
  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.bad = 1'b0;
    h.val = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      h.val = 4'(b - 8'h30);
    end else if (b inside {[8'h41:8'h46]}) begin
      h.val = 4'(b - 8'h37);
    end else if (b inside {[8'h61:8'h66]}) begin
      h.val = 4'(b - 8'h57);
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

FILE: hdl/nmea_sentence_validator_unit.sv
// NMEA 0183 sentence checker: frame, printable body, XOR checksum, header kind.
// Depends on nsv_pkg.
//
// A tlast byte is registered in the input stage, its result in the result stage.
// Throughput: one byte per cycle; the input stalls only while a result waits downstream.
// Reset (async, low): sentence state cleared, max_body back to 120, no result pending.
module nmea_sentence_validator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,    // max_body
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] error_code, [10:3] computed_sum, rest zero
  output logic [3:0]  m_axis_tuser    // [0] valid_res, [3:1] sentence_kind
);

  typedef enum logic [2:0] {
    PH_DOLLAR,
    PH_BODY,
    PH_DIG1,
    PH_DIG2,
    PH_DONE
  } phase_e;

  logic [7:0] max_body_q;

  // input stage
  logic       in_vld_q;
  logic [7:0] in_data_q;
  logic       in_last_q;

  // sentence state
  phase_e     phase_q, phase_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] cnt_q, cnt_d;
  logic [3:0] rx_nib_q, rx_nib_d;
  logic [2:0] err_q, err_d;
  logic [2:0] hpos_q, hpos_d;
  logic [3:0] cand_q, cand_d;

  // result stage
  logic       out_vld_q;
  logic [2:0] out_err_q, out_err_d;
  logic [2:0] out_kind_q, out_kind_d;
  logic [7:0] out_sum_q;

  logic       proc_adv;
  logic       emit;
  nsv_pkg::hex_t hx;

  assign proc_adv      = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready);
  assign emit          = proc_adv && in_last_q;
  assign s_axis_tready = !in_vld_q || proc_adv;

  assign hx = nsv_pkg::hex_decode(in_data_q);

  always_comb begin
    phase_d  = phase_q;
    xor_d    = xor_q;
    cnt_d    = cnt_q;
    rx_nib_d = rx_nib_q;
    err_d    = err_q;
    hpos_d   = hpos_q;
    cand_d   = cand_q;

    // header match over the first six bytes
    if (hpos_q < 3'(nsv_pkg::HDR_LEN)) begin
      for (int k = 0; k < nsv_pkg::NUM_KINDS; k++) begin
        if (in_data_q != nsv_pkg::hdr_byte(2'(k), hpos_q)) begin
          cand_d[k] = 1'b0;
        end
      end
      hpos_d = (in_data_q == nsv_pkg::CH_NUL) ? 3'(nsv_pkg::HDR_LEN) : hpos_q + 3'd1;
    end

    case (phase_q)
      PH_DOLLAR: begin
        if (in_data_q == nsv_pkg::CH_DOLLAR) begin
          phase_d = PH_BODY;
        end else begin
          err_d   = nsv_pkg::ERR_DOLLAR;
          phase_d = PH_DONE;
        end
      end
      PH_BODY: begin
        if (in_data_q == nsv_pkg::CH_NUL) begin
          err_d   = nsv_pkg::ERR_STAR;
          phase_d = PH_DONE;
        end else if (in_data_q == nsv_pkg::CH_STAR) begin
          phase_d = PH_DIG1;
        end else if (cnt_q >= max_body_q) begin
          err_d   = nsv_pkg::ERR_STAR;
          phase_d = PH_DONE;
        end else if (!(in_data_q inside {[nsv_pkg::PRINT_LO:nsv_pkg::PRINT_HI]})) begin
          err_d   = nsv_pkg::ERR_CHAR;
          phase_d = PH_DONE;
        end else begin
          xor_d = xor_q ^ in_data_q;
          cnt_d = cnt_q + 8'd1;
        end
      end
      PH_DIG1: begin
        if (in_data_q == nsv_pkg::CH_NUL) begin
          err_d   = nsv_pkg::ERR_DIGITS;
          phase_d = PH_DONE;
        end else begin
          // a bad first digit is held back until the second digit shows up
          if (hx.bad) begin
            err_d = nsv_pkg::ERR_HEX;
          end else begin
            rx_nib_d = hx.val;
          end
          phase_d = PH_DIG2;
        end
      end
      PH_DIG2: begin
        phase_d = PH_DONE;
        if (in_data_q == nsv_pkg::CH_NUL) begin
          err_d = nsv_pkg::ERR_DIGITS;
        end else if (err_q == nsv_pkg::ERR_HEX || hx.bad) begin
          err_d = nsv_pkg::ERR_HEX;
        end else if ({rx_nib_q, hx.val} == xor_q) begin
          err_d = nsv_pkg::ERR_OK;
        end else begin
          err_d = nsv_pkg::ERR_MISMATCH;
        end
      end
      default: ;
    endcase

    case (phase_d)
      PH_DOLLAR: out_err_d = nsv_pkg::ERR_DOLLAR;
      PH_BODY:   out_err_d = nsv_pkg::ERR_STAR;
      PH_DIG1,
      PH_DIG2:   out_err_d = nsv_pkg::ERR_DIGITS;
      default:   out_err_d = err_d;
    endcase

    // lowest set candidate wins
    out_kind_d = 3'd0;
    if (out_err_d == nsv_pkg::ERR_OK && hpos_d >= 3'(nsv_pkg::HDR_LEN)) begin
      for (int k = nsv_pkg::NUM_KINDS - 1; k >= 0; k--) begin
        if (cand_d[k]) begin
          out_kind_d = 3'(k + 1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= nsv_pkg::MAX_BODY_RST;
      in_vld_q   <= 1'b0;
      phase_q    <= PH_DOLLAR;
      xor_q      <= 8'd0;
      cnt_q      <= 8'd0;
      rx_nib_q   <= 4'd0;
      err_q      <= nsv_pkg::ERR_OK;
      hpos_q     <= 3'd0;
      cand_q     <= '1;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_body_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (proc_adv) begin
        if (in_last_q) begin
          phase_q  <= PH_DOLLAR;
          xor_q    <= 8'd0;
          cnt_q    <= 8'd0;
          rx_nib_q <= 4'd0;
          err_q    <= nsv_pkg::ERR_OK;
          hpos_q   <= 3'd0;
          cand_q   <= '1;
        end else begin
          phase_q  <= phase_d;
          xor_q    <= xor_d;
          cnt_q    <= cnt_d;
          rx_nib_q <= rx_nib_d;
          err_q    <= err_d;
          hpos_q   <= hpos_d;
          cand_q   <= cand_d;
        end
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (emit) begin
      out_err_q  <= out_err_d;
      out_kind_q <= out_kind_d;
      out_sum_q  <= xor_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_sum_q, out_err_q};
  assign m_axis_tuser  = {out_kind_q, (out_err_q == nsv_pkg::ERR_OK)};

endmodule

FILE: hdl/nsv_checker.sv
// Port-level checker for nmea_sentence_validator_unit, bound to every instance of it.
// Depends on nsv_pkg.
module nsv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_valid_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[2:0] == nsv_pkg::ERR_OK)))
    else $error("valid_res disagrees with error_code");

  a_kind_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[3:1] != 3'd0) |-> m_axis_tuser[0])
    else $error("sentence kind on a failed sentence");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd7) && (m_axis_tuser[3:1] <= 3'd4)
      && (m_axis_tdata[15:11] == 5'd0))
    else $error("result code out of range");

endmodule

bind nmea_sentence_validator_unit nsv_checker u_nsv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for nmea_sentence_validator_unit: byte stream in, one verdict
// per sentence out, compared against table rows or a cycle-free scanner kept here.
// Depends on nsv_pkg and the unit under test.
module tb;

  localparam int unsigned LIMIT   = 400000;
  localparam int unsigned PHASE_B = 160;   // random bytes per max_body setting

  localparam logic [2:0] KIND_OTHER = 3'd0;
  localparam logic [2:0] KIND_GGA   = 3'd1;
  localparam logic [2:0] KIND_GLL   = 3'd2;
  localparam logic [2:0] KIND_RMC   = 3'd3;
  localparam logic [2:0] KIND_VTG   = 3'd4;

  typedef enum logic [2:0] {SC_DOLLAR, SC_BODY, SC_DIG1, SC_DIG2, SC_DONE} scan_ph_e;

  typedef struct packed {
    logic       ok;
    logic [2:0] err;
    logic [2:0] kind;
    logic [7:0] sum;
  } verdict_t;

  typedef struct {
    logic [7:0] max_body;
    string      text;
    int         patch_pos;
    logic [7:0] patch_val;
    bit         typed;
    verdict_t   want;
  } row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] data_byte
  logic        s_axis_tlast  = 1'b0;   // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [2:0] error_code, [10:3] computed_sum
  logic [3:0]  m_axis_tuser;           // [0] valid_res, [3:1] sentence_kind

  nmea_sentence_validator_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- scanner
  string kind_hdr [nsv_pkg::NUM_KINDS] = '{"$GNGGA", "$GNGLL", "$GNRMC", "$GNVTG"};

  scan_ph_e   scan_ph;
  logic [7:0] limit_body = nsv_pkg::MAX_BODY_RST;
  logic [7:0] xor_acc, body_cnt, rx_sum;
  logic [2:0] err_latch, hdr_pos;
  logic [3:0] kind_mask;

  verdict_t verdict_q[$];
  logic [7:0] frame_q[$];
  row_t dir_rows[$];

  int unsigned cycles, mismatches, results_seen, valid_seen, frames_sent, bytes_sent;
  int unsigned burst_left;
  bit          gaps_on;
  int          rx_mode;

  function void clear_scan();
    scan_ph   = SC_DOLLAR;
    xor_acc   = 8'd0;
    body_cnt  = 8'd0;
    rx_sum    = 8'd0;
    err_latch = nsv_pkg::ERR_OK;
    hdr_pos   = 3'd0;
    kind_mask = 4'hF;
  endfunction

  function void halt(input logic [2:0] code);
    err_latch = code;
    scan_ph   = SC_DONE;
  endfunction

  // 0..15 for a hex digit of either case, 16 otherwise
  function automatic int hex_nib(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
    return 16;
  endfunction

  function void scan_byte(input logic [7:0] b, input logic last, output bit done,
                          output verdict_t v);
    int         nib;
    logic [7:0] hb;
    logic [2:0] err;
    done = 1'b0;
    v    = '0;
    if (hdr_pos < nsv_pkg::HDR_LEN) begin
      for (int k = 0; k < nsv_pkg::NUM_KINDS; k++) begin
        hb = kind_hdr[k][hdr_pos];
        if (b != hb) kind_mask[k] = 1'b0;
      end
      hdr_pos = (b == nsv_pkg::CH_NUL) ? 3'(nsv_pkg::HDR_LEN) : hdr_pos + 3'd1;
    end
    case (scan_ph)
      SC_DOLLAR: begin
        if (b == nsv_pkg::CH_DOLLAR) scan_ph = SC_BODY;
        else halt(nsv_pkg::ERR_DOLLAR);
      end
      SC_BODY: begin
        if (b == nsv_pkg::CH_NUL) halt(nsv_pkg::ERR_STAR);
        else if (b == nsv_pkg::CH_STAR) scan_ph = SC_DIG1;
        else if (body_cnt >= limit_body) halt(nsv_pkg::ERR_STAR);
        else if (b < nsv_pkg::PRINT_LO || b > nsv_pkg::PRINT_HI) halt(nsv_pkg::ERR_CHAR);
        else begin
          xor_acc  = xor_acc ^ b;
          body_cnt = body_cnt + 8'd1;
        end
      end
      SC_DIG1: begin
        if (b == nsv_pkg::CH_NUL) halt(nsv_pkg::ERR_DIGITS);
        else begin
          nib = hex_nib(b);
          // a bad first digit only counts once the second one shows up
          if (nib > 15) err_latch = nsv_pkg::ERR_HEX;
          else rx_sum = 8'(nib);
          scan_ph = SC_DIG2;
        end
      end
      SC_DIG2: begin
        if (b == nsv_pkg::CH_NUL) halt(nsv_pkg::ERR_DIGITS);
        else begin
          nib = hex_nib(b);
          if (err_latch == nsv_pkg::ERR_HEX || nib > 15) halt(nsv_pkg::ERR_HEX);
          else begin
            rx_sum = {rx_sum[3:0], 4'(nib)};
            halt((rx_sum == xor_acc) ? nsv_pkg::ERR_OK : nsv_pkg::ERR_MISMATCH);
          end
        end
      end
      default: ;
    endcase
    if (last) begin
      case (scan_ph)
        SC_DOLLAR:        err = nsv_pkg::ERR_DOLLAR;
        SC_BODY:          err = nsv_pkg::ERR_STAR;
        SC_DIG1, SC_DIG2: err = nsv_pkg::ERR_DIGITS;
        default:          err = err_latch;
      endcase
      v.kind = KIND_OTHER;
      if (err == nsv_pkg::ERR_OK && hdr_pos >= nsv_pkg::HDR_LEN) begin
        // walk down so the lowest surviving candidate wins
        for (int k = nsv_pkg::NUM_KINDS - 1; k >= 0; k--) begin
          if (kind_mask[k]) v.kind = 3'(k + 1);
        end
      end
      v.ok  = (err == nsv_pkg::ERR_OK);
      v.err = err;
      v.sum = xor_acc;
      done  = 1'b1;
      clear_scan();
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic string with_sum(input string body, input bit lower);
    logic [7:0] x;
    x = 8'd0;
    for (int i = 0; i < body.len(); i++) x = x ^ body[i];
    return {"$", body, "*", lower ? $sformatf("%02x", x) : $sformatf("%02X", x)};
  endfunction

  function void add_row(input logic [7:0] mb, input string text, input int ppos,
                        input logic [7:0] pval, input bit typed, input logic ok,
                        input logic [2:0] err, input logic [2:0] kind, input logic [7:0] sum);
    row_t r;
    r.max_body  = mb;
    r.text      = text;
    r.patch_pos = ppos;
    r.patch_val = pval;
    r.typed     = typed;
    r.want      = '{ok: ok, err: err, kind: kind, sum: sum};
    dir_rows.push_back(r);
  endfunction

  function void make_random_frame();
    int         r, len, cnt, cut;
    logic [7:0] x, c, sent_sum;
    string      hdr;
    frame_q.delete();
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // line noise
      repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    frame_q.push_back(nsv_pkg::CH_DOLLAR);
    x   = 8'd0;
    cnt = 0;
    if ($urandom_range(0, (limit_body > 32) ? 19 : 4) == 0) begin
      len = int'(limit_body) + $urandom_range(0, 2) - 1;
      if (len < 0) len = 0;
    end else begin
      len = $urandom_range(0, 12);
    end
    if ($urandom_range(0, 1)) begin
      hdr = {kind_hdr[$urandom_range(0, nsv_pkg::NUM_KINDS - 1)].substr(1, 5), ","};
      for (int i = 0; i < hdr.len(); i++) begin
        c = hdr[i];
        frame_q.push_back(c);
        x = x ^ c;
        cnt++;
      end
    end
    while (cnt < len) begin
      do c = 8'($urandom_range(32, 126)); while (c == nsv_pkg::CH_STAR);
      frame_q.push_back(c);
      x = x ^ c;
      cnt++;
    end
    if ($urandom_range(0, 9) != 0) frame_q.push_back(nsv_pkg::CH_STAR);
    sent_sum = ($urandom_range(0, 3) != 0) ? x : 8'($urandom_range(0, 255));
    frame_q.push_back(hex_char(sent_sum[7:4], 1'($urandom_range(0, 1))));
    frame_q.push_back(hex_char(sent_sum[3:0], 1'($urandom_range(0, 1))));
    if ($urandom_range(0, 9) == 0) frame_q[frame_q.size() - 1 - $urandom_range(0, 1)] =
                                     8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 1)) begin
        frame_q.push_back(8'h0D);
        frame_q.push_back(8'h0A);
      end else begin
        repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 6) == 0)
      frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 19) == 0) begin
      cut = $urandom_range(1, frame_q.size());
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_byte(input logic [7:0] b, input logic last, output bit done,
                           output verdict_t v);
    if (gaps_on && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left != 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    scan_byte(b, last, done, v);
  endtask

  task automatic send_frame(input bit typed, input verdict_t want);
    bit       done;
    verdict_t v;
    for (int i = 0; i < frame_q.size(); i++) begin
      send_byte(frame_q[i], i == frame_q.size() - 1, done, v);
      if (done) verdict_q.push_back(typed ? want : v);
    end
    frames_sent++;
  endtask

  task automatic write_max_body(input logic [7:0] val);
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    limit_body = val;
  endtask

  // ---------------------------------------------------------------- result side
  always @(posedge clk_i) begin : rx_side
    verdict_t w, got;
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results outstanding", cycles,
               verdict_q.size());
      $display("tb: errors");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{ok: m_axis_tuser[0], err: m_axis_tdata[2:0], kind: m_axis_tuser[3:1],
              sum: m_axis_tdata[10:3]};
      results_seen++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: result with no request pending: %p", got);
      end else begin
        w = verdict_q.pop_front();
        if (w.ok) valid_seen++;
        if (got.ok !== w.ok || got.err !== w.err || got.kind !== w.kind ||
            got.sum !== w.sum) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: result %0d: want ok=%0b err=%0d kind=%0d sum=%02h, ",
                     results_seen, w.ok, w.err, w.kind, w.sum,
                     "got ok=%0b err=%0d kind=%0d sum=%02h",
                     got.ok, got.err, got.kind, got.sum);
        end
      end
    end
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ((cycles % 11) >= 4);
    endcase
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    string         long_a;
    logic [7:0]    plan [5];
    int unsigned   target;
    clear_scan();
    gaps_on    = 1'b1;
    rx_mode    = 1;
    burst_left = 0;
    long_a     = "";
    repeat (255) long_a = {long_a, "A"};

    add_row(8'd120, "X$A*41", -1, 8'h00, 1'b1, 1'b0, nsv_pkg::ERR_DOLLAR, KIND_OTHER, 8'h00);
    add_row(8'd120, "$", -1, 8'h00, 1'b1, 1'b0, nsv_pkg::ERR_STAR, KIND_OTHER, 8'h00);
    add_row(8'd120, "$*00", -1, 8'h00, 1'b1, 1'b1, nsv_pkg::ERR_OK, KIND_OTHER, 8'h00);
    add_row(8'd120, "$*", -1, 8'h00, 1'b1, 1'b0, nsv_pkg::ERR_DIGITS, KIND_OTHER, 8'h00);
    add_row(8'd120, "$*G", -1, 8'h00, 1'b1, 1'b0, nsv_pkg::ERR_DIGITS, KIND_OTHER, 8'h00);
    add_row(8'd120, "$*G0", -1, 8'h00, 1'b1, 1'b0, nsv_pkg::ERR_HEX, KIND_OTHER, 8'h00);
    add_row(8'd120, "$*0G", -1, 8'h00, 1'b1, 1'b0, nsv_pkg::ERR_HEX, KIND_OTHER, 8'h00);
    add_row(8'd120, "$*01", -1, 8'h00, 1'b1, 1'b0, nsv_pkg::ERR_MISMATCH, KIND_OTHER,
            8'h00);
    add_row(8'd120, "$A*41\r\n", -1, 8'h00, 1'b1, 1'b1, nsv_pkg::ERR_OK, KIND_OTHER, 8'h41);
    add_row(8'd120, "$j*6a", -1, 8'h00, 1'b1, 1'b1, nsv_pkg::ERR_OK, KIND_OTHER, 8'h6A);
    add_row(8'd120, "$ ~*5E", -1, 8'h00, 1'b1, 1'b1, nsv_pkg::ERR_OK, KIND_OTHER, 8'h5E);
    add_row(8'd120, "$AB*41", 2, 8'h1F, 1'b1, 1'b0, nsv_pkg::ERR_CHAR, KIND_OTHER, 8'h41);
    add_row(8'd120, "$AB*41", 2, 8'h7F, 1'b1, 1'b0, nsv_pkg::ERR_CHAR, KIND_OTHER, 8'h41);
    add_row(8'd120, "$AB*41", 1, 8'hFF, 1'b1, 1'b0, nsv_pkg::ERR_CHAR, KIND_OTHER, 8'h00);
    // zero byte ends the sentence in the body, then after the star
    add_row(8'd120, "$AB*03", 2, 8'h00, 1'b1, 1'b0, nsv_pkg::ERR_STAR, KIND_OTHER, 8'h41);
    add_row(8'd120, "$A*41", 3, 8'h00, 1'b1, 1'b0, nsv_pkg::ERR_DIGITS, KIND_OTHER, 8'h41);
    add_row(8'd120, with_sum("GNGGA,123519,4807.038,N", 1'b0), -1, 8'h00, 1'b0, 1'b0,
            nsv_pkg::ERR_OK, KIND_OTHER, 8'h00);
    add_row(8'd120, with_sum("GNGLL,4916.45,N", 1'b1), -1, 8'h00, 1'b0, 1'b0,
            nsv_pkg::ERR_OK, KIND_OTHER, 8'h00);
    add_row(8'd120, with_sum("GNRMC,081836,A", 1'b0), -1, 8'h00, 1'b0, 1'b0,
            nsv_pkg::ERR_OK, KIND_OTHER, 8'h00);
    add_row(8'd120, with_sum("GNVTG", 1'b1), -1, 8'h00, 1'b0, 1'b0,
            nsv_pkg::ERR_OK, KIND_OTHER, 8'h00);
    add_row(8'd120, with_sum("GNGG", 1'b0), -1, 8'h00, 1'b0, 1'b0,
            nsv_pkg::ERR_OK, KIND_OTHER, 8'h00);
    // body limit: next byte after max_body must be the star
    add_row(8'd1, "$AB*03", -1, 8'h00, 1'b1, 1'b0, nsv_pkg::ERR_STAR, KIND_OTHER, 8'h41);
    add_row(8'd1, "$A*41", -1, 8'h00, 1'b1, 1'b1, nsv_pkg::ERR_OK, KIND_OTHER, 8'h41);
    add_row(8'd1, "$AB*41", 2, 8'hFF, 1'b1, 1'b0, nsv_pkg::ERR_STAR, KIND_OTHER, 8'h41);
    add_row(8'd0, "$*00", -1, 8'h00, 1'b1, 1'b1, nsv_pkg::ERR_OK, KIND_OTHER, 8'h00);
    add_row(8'd0, "$A*41", -1, 8'h00, 1'b1, 1'b0, nsv_pkg::ERR_STAR, KIND_OTHER, 8'h00);
    add_row(8'd255, {"$", long_a, "*41"}, -1, 8'h00, 1'b1, 1'b1,
            nsv_pkg::ERR_OK, KIND_OTHER, 8'h41);
    add_row(8'd255, {"$", long_a, "A*00"}, -1, 8'h00, 1'b1, 1'b0,
            nsv_pkg::ERR_STAR, KIND_OTHER, 8'h41);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].max_body != limit_body) write_max_body(dir_rows[i].max_body);
      frame_q.delete();
      for (int j = 0; j < dir_rows[i].text.len(); j++) frame_q.push_back(dir_rows[i].text[j]);
      if (dir_rows[i].patch_pos >= 0) frame_q[dir_rows[i].patch_pos] = dir_rows[i].patch_val;
      send_frame(dir_rows[i].typed, dir_rows[i].want);
    end

    plan = '{8'd255, 8'd1, 8'd8, 8'($urandom_range(1, 255)), nsv_pkg::MAX_BODY_RST};
    for (int p = 0; p < 5; p++) begin
      write_max_body(plan[p]);
      gaps_on    = (p % 2 == 0);
      rx_mode    = p % 3;
      burst_left = 0;
      target     = bytes_sent + PHASE_B;
      while (bytes_sent < target) begin
        make_random_frame();
        send_frame(1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("tb: %0d sentences (%0d bytes) sent, %0d verdicts checked, %0d of them valid",
             frames_sent, bytes_sent, results_seen, valid_seen);
    $display("tb: max_body swept over 0, 1, 8, 120, 255 and a random value; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
